@@ hw/rtl/crb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int MAX_KERNEL = 5;
    localparam int ROWS_LIMIT = 4096;
    localparam int NUM_TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int RING_ROWS  = MAX_KERNEL + 1;
    localparam int PHASES     = MAX_KERNEL;
    localparam int BANK_DEPTH = (MAX_LINE + PHASES - 1) / PHASES;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int SLOT_W     = $clog2(RING_ROWS);
    localparam int PHASE_W    = $clog2(PHASES);
    localparam int TAP_W      = $clog2(NUM_TAPS + 1);
    localparam int SUM_W      = 30;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL_ROWS  = 2'd2;
    localparam logic [1:0] REG_KERNEL_COLS  = 2'd3;

    typedef enum logic [1:0] {
        TK_NONE,
        TK_LOAD,
        TK_RESULT
    } tok_kind_t;

    typedef logic [NUM_TAPS-1:0][7:0] pix_vec_t;

    typedef struct packed {
        tok_kind_t               kind;
        logic signed [SUM_W-1:0] sum;
        pix_vec_t                pix;
        logic [TAP_W-1:0]        tap;
        logic signed [15:0]      value;
        logic [9:0]              x;
        logic [11:0]             y;
        logic                    eof;
    } tok_t;

    typedef logic [RING_ROWS-1:0][PHASES-1:0][7:0] bank_data_t;
    typedef logic [PHASES-1:0][BANK_AW-1:0] bank_addr_t;

    typedef struct packed {
        logic               eof;
        logic [11:0]        y;
        logic [9:0]         x;
        logic signed [15:0] filtered;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/crb_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crb_line_store import crb_pkg::*; (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_slot,
    input  logic [PHASE_W-1:0]  wr_phase,
    input  logic [BANK_AW-1:0]  wr_addr,
    input  logic [7:0]          wr_data,
    input  bank_addr_t          rd_addr,
    output bank_data_t          rd_data
);

    for (genvar s = 0; s < RING_ROWS; s++) begin : g_slot
        for (genvar b = 0; b < PHASES; b++) begin : g_phase
            logic [7:0] bank_mem [BANK_DEPTH];
            logic [7:0] rd_reg;

            always_ff @(posedge aclk) begin
                if (wr_en && wr_slot == SLOT_W'(s) && wr_phase == PHASE_W'(b)) begin
                    bank_mem[wr_addr] <= wr_data;
                end
                rd_reg <= bank_mem[rd_addr[b]];
            end

            assign rd_data[s][b] = rd_reg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/crb_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crb_cell import crb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic signed [15:0] coef_reg, coef_next;
    tok_t               tok_reg, tok_next;
    logic signed [23:0] prod;

    assign prod = coef_reg * $signed({1'b0, tok_in.pix[0]});

    always_comb begin
        tok_next     = tok_in;
        coef_next    = coef_reg;
        tok_next.pix = {8'd0, tok_in.pix[NUM_TAPS-1:1]};
        tok_next.tap = tok_in.tap - TAP_W'(1);
        if (tok_in.kind == TK_LOAD && tok_in.tap == '0) begin
            coef_next = tok_in.value;
        end
        if (tok_in.kind == TK_RESULT) begin
            tok_next.sum = tok_in.sum + SUM_W'(prod);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.kind <= TK_NONE;
            coef_reg     <= '0;
        end else begin
            tok_reg  <= tok_next;
            coef_reg <= coef_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ hw/rtl/crb_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crb_out_fifo import crb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  res_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output res_t rd_data
);

    res_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW:0]   rd_ptr_reg, rd_ptr_next;

    assign rd_valid    = wr_ptr_reg != rd_ptr_reg;
    assign rd_data     = fifo_mem[rd_ptr_reg[FIFO_AW-1:0]];
    assign wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (rd_valid && rd_ready) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_mem[wr_ptr_reg[FIFO_AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/conv2d_replicate_border.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 2D convolution of a raster pixel stream with a kernel of up to 5x5 signed Q4.12
// coefficients, borders replicated from the nearest edge pixel. The block takes one
// transaction per clock while s_tready is high: coefficient loads, pixels and flush
// steps all enter at full rate. A result passes through line-store addressing and
// read, then a chain of 25 multiply-accumulate cells, one per kernel tap, and waits
// in a 32-entry output queue; s_tready drops only while 32 results are in flight
// or queued. The line store is six rows of 1024 pixels split into 30 banks so all
// 25 window pixels are read at once. Any configuration write restarts the frame;
// coefficients are kept.
module conv2d_replicate_border import crb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // coef_row, coef_col, coef_value, pixel
    input  logic [1:0]  s_tuser,     // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // filtered, out_x, out_y
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wr_data
);

    typedef struct packed {
        tok_kind_t            kind;
        logic [9:0]           x;
        logic [BANK_AW-1:0]   q;
        logic [PHASE_W-1:0]   r;
        logic [11:0]          y;
        logic [SLOT_W-1:0]    s;
        logic                 eof;
        logic [TAP_W-1:0]     tap;
        logic signed [15:0]   value;
    } s1_t;

    typedef struct packed {
        tok_kind_t                          kind;
        logic [MAX_KERNEL-1:0][SLOT_W-1:0]  slot;
        logic [MAX_KERNEL-1:0][PHASE_W-1:0] phase;
        logic [9:0]                         x;
        logic [11:0]                        y;
        logic                               eof;
        logic [TAP_W-1:0]                   tap;
        logic signed [15:0]                 value;
    } s2_t;

    localparam int Q_W = SUM_W - 11;

    logic [10:0] fw_reg;
    logic [12:0] fh_reg;
    logic [2:0]  kr_reg, kc_reg;

    logic [10:0] w;
    logic [12:0] h;
    logic [2:0]  kr, kc, dr, dc, up_r, up_c;
    logic [9:0]  wm1;
    logic [11:0] hm1;

    logic [9:0]          in_x_reg, in_x_next, ex_reg, ex_next;
    logic [BANK_AW-1:0]  in_q_reg, in_q_next, exq_reg, exq_next;
    logic [PHASE_W-1:0]  in_r_reg, in_r_next, exr_reg, exr_next;
    logic [11:0]         in_y_reg, in_y_next, ey_reg, ey_next;
    logic [SLOT_W-1:0]   in_s_reg, in_s_next, eys_reg, eys_next;
    logic                tail_reg, tail_next;
    logic [FIFO_AW:0]    pend_reg, pend_next;

    logic [1:0]  func;
    logic [2:0]  coef_row, coef_col;
    logic [15:0] coef_value;
    logic [7:0]  pixel;
    logic        acc, is_pix, is_flush, is_load, emit, pop;
    logic [10:0] nx_w;
    logic [12:0] ny_w;
    logic [9:0]  nx;
    logic [11:0] ny;
    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;

    logic [1:0]  lo_x, hi_x, lo_y, hi_y;
    logic [9:0]  rem_x;
    logic [11:0] rem_y;
    bank_addr_t  rd_addr;
    bank_data_t  rd_data;
    logic [3:0]  be [PHASES];
    logic [3:0]  bd [PHASES];
    logic [3:0]  bu [PHASES];
    logic signed [4:0] roff [MAX_KERNEL];
    logic signed [4:0] rv   [MAX_KERNEL];
    logic signed [4:0] coff [MAX_KERNEL];
    logic signed [4:0] cv   [MAX_KERNEL];

    tok_t gather_tok;
    tok_t cell_q [NUM_TAPS];
    tok_t last_tok;
    logic signed [SUM_W:0] rnd;
    logic signed [Q_W-1:0] qv;
    res_t fifo_wr, fifo_rd;

    // field unpacking
    assign func       = s_tuser;
    assign coef_row   = s_tdata[2:0];
    assign coef_col   = s_tdata[5:3];
    assign coef_value = s_tdata[21:6];
    assign pixel      = s_tdata[29:22];

    // clamped configuration
    assign w    = (fw_reg == '0) ? 11'd1 : ((fw_reg > 11'(MAX_LINE)) ? 11'(MAX_LINE) : fw_reg);
    assign h    = (fh_reg == '0) ? 13'd1 :
                  ((fh_reg > 13'(ROWS_LIMIT)) ? 13'(ROWS_LIMIT) : fh_reg);
    assign kr   = (kr_reg == '0) ? 3'd1 : ((kr_reg > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kr_reg);
    assign kc   = (kc_reg == '0) ? 3'd1 : ((kc_reg > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kc_reg);
    assign up_r = kr >> 1;
    assign up_c = kc >> 1;
    assign dr   = kr - 3'd1 - up_r;
    assign dc   = kc - 3'd1 - up_c;
    assign wm1  = 10'(w - 11'd1);
    assign hm1  = 12'(h - 13'd1);

    assign s_tready = pend_reg < (FIFO_AW + 1)'(FIFO_DEPTH);
    assign acc      = s_tvalid && s_tready;
    assign is_pix   = acc && (func == FUNC_PIXEL);
    assign is_flush = acc && (func == FUNC_FLUSH);
    assign is_load  = acc && (func == FUNC_LOAD);
    assign pop      = m_tvalid && m_tready;

    // frame position control
    always_comb begin
        in_x_next = in_x_reg;
        in_q_next = in_q_reg;
        in_r_next = in_r_reg;
        in_y_next = in_y_reg;
        in_s_next = in_s_reg;
        ex_next   = ex_reg;
        exq_next  = exq_reg;
        exr_next  = exr_reg;
        ey_next   = ey_reg;
        eys_next  = eys_reg;
        tail_next = tail_reg;
        s1_next   = '0;
        s1_next.kind = TK_NONE;

        if (is_pix) begin
            if (tail_next) begin
                tail_next = 1'b0;
                ex_next   = '0;
                exq_next  = '0;
                exr_next  = '0;
                ey_next   = '0;
                eys_next  = '0;
            end
            if (in_x_next == wm1) begin
                in_x_next = '0;
                in_q_next = '0;
                in_r_next = '0;
                if (in_y_next == hm1) begin
                    in_y_next = '0;
                    in_s_next = '0;
                    tail_next = 1'b1;
                end else begin
                    in_y_next = in_y_next + 12'd1;
                    in_s_next = (in_s_next == SLOT_W'(RING_ROWS - 1)) ? '0 :
                                in_s_next + SLOT_W'(1);
                end
            end else begin
                in_x_next = in_x_next + 10'd1;
                if (in_r_next == PHASE_W'(PHASES - 1)) begin
                    in_r_next = '0;
                    in_q_next = in_q_next + BANK_AW'(1);
                end else begin
                    in_r_next = in_r_next + PHASE_W'(1);
                end
            end
        end

        nx_w = {1'b0, ex_next} + 11'(dc);
        ny_w = {1'b0, ey_next} + 13'(dr);
        nx   = (nx_w > {1'b0, wm1}) ? wm1 : nx_w[9:0];
        ny   = (ny_w > {1'b0, hm1}) ? hm1 : ny_w[11:0];
        emit = (is_pix || is_flush) &&
               (tail_next || (!(in_x_next == '0 && in_y_next == '0) &&
                              ((ny < in_y_next) || (ny == in_y_next && nx < in_x_next))));

        if (emit) begin
            s1_next.kind = TK_RESULT;
            s1_next.x    = ex_next;
            s1_next.q    = exq_next;
            s1_next.r    = exr_next;
            s1_next.y    = ey_next;
            s1_next.s    = eys_next;
            s1_next.eof  = (ex_next == wm1) && (ey_next == hm1);
            if (ex_next == wm1) begin
                ex_next  = '0;
                exq_next = '0;
                exr_next = '0;
                if (ey_next == hm1) begin
                    ey_next   = '0;
                    eys_next  = '0;
                    tail_next = 1'b0;
                end else begin
                    ey_next  = ey_next + 12'd1;
                    eys_next = (eys_next == SLOT_W'(RING_ROWS - 1)) ? '0 :
                               eys_next + SLOT_W'(1);
                end
            end else begin
                ex_next = ex_next + 10'd1;
                if (exr_next == PHASE_W'(PHASES - 1)) begin
                    exr_next = '0;
                    exq_next = exq_next + BANK_AW'(1);
                end else begin
                    exr_next = exr_next + PHASE_W'(1);
                end
            end
        end

        if (is_load && coef_row < 3'(MAX_KERNEL) && coef_col < 3'(MAX_KERNEL)) begin
            s1_next.kind  = TK_LOAD;
            s1_next.tap   = TAP_W'(coef_row) * TAP_W'(MAX_KERNEL) + TAP_W'(coef_col);
            s1_next.value = coef_value;
        end

        pend_next = pend_reg + (FIFO_AW + 1)'(emit) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= 11'd640;
            fh_reg      <= 13'd480;
            kr_reg      <= 3'd3;
            kc_reg      <= 3'd3;
            in_x_reg    <= '0;
            in_q_reg    <= '0;
            in_r_reg    <= '0;
            in_y_reg    <= '0;
            in_s_reg    <= '0;
            ex_reg      <= '0;
            exq_reg     <= '0;
            exr_reg     <= '0;
            ey_reg      <= '0;
            eys_reg     <= '0;
            tail_reg    <= 1'b0;
            pend_reg    <= '0;
            s1_reg.kind <= TK_NONE;
            s2_reg.kind <= TK_NONE;
        end else begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            pend_reg <= pend_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_wr_data[10:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_wr_data;
                    REG_KERNEL_ROWS:  kr_reg <= cfg_wr_data[2:0];
                    REG_KERNEL_COLS:  kc_reg <= cfg_wr_data[2:0];
                    default:          fw_reg <= fw_reg;
                endcase
                in_x_reg <= '0;
                in_q_reg <= '0;
                in_r_reg <= '0;
                in_y_reg <= '0;
                in_s_reg <= '0;
                ex_reg   <= '0;
                exq_reg  <= '0;
                exr_reg  <= '0;
                ey_reg   <= '0;
                eys_reg  <= '0;
                tail_reg <= 1'b0;
            end else begin
                in_x_reg <= in_x_next;
                in_q_reg <= in_q_next;
                in_r_reg <= in_r_next;
                in_y_reg <= in_y_next;
                in_s_reg <= in_s_next;
                ex_reg   <= ex_next;
                exq_reg  <= exq_next;
                exr_reg  <= exr_next;
                ey_reg   <= ey_next;
                eys_reg  <= eys_next;
                tail_reg <= tail_next;
            end
        end
    end

    // window addressing: bank addresses, ring slots and column phases
    always_comb begin
        rem_x = wm1 - s1_reg.x;
        rem_y = hm1 - s1_reg.y;
        lo_x  = (s1_reg.x < 10'd2) ? s1_reg.x[1:0] : 2'd2;
        hi_x  = (rem_x < 10'd2) ? rem_x[1:0] : 2'd2;
        lo_y  = (s1_reg.y < 12'd2) ? s1_reg.y[1:0] : 2'd2;
        hi_y  = (rem_y < 12'd2) ? rem_y[1:0] : 2'd2;

        for (int b = 0; b < PHASES; b++) begin
            be[b] = 4'(b) + 4'(PHASES) - 4'(s1_reg.r);
            bd[b] = (be[b] >= 4'(PHASES)) ? be[b] - 4'(PHASES) : be[b];
            bu[b] = 4'(s1_reg.r) + bd[b];
            if (bd[b] <= 4'd2) begin
                rd_addr[b] = (bu[b] >= 4'(PHASES)) ? s1_reg.q + BANK_AW'(1) : s1_reg.q;
            end else begin
                rd_addr[b] = (bu[b] < 4'(PHASES)) ? s1_reg.q - BANK_AW'(1) : s1_reg.q;
            end
        end

        s2_next       = '0;
        s2_next.kind  = s1_reg.kind;
        s2_next.x     = s1_reg.x;
        s2_next.y     = s1_reg.y;
        s2_next.eof   = s1_reg.eof;
        s2_next.tap   = s1_reg.tap;
        s2_next.value = s1_reg.value;

        for (int k = 0; k < MAX_KERNEL; k++) begin
            roff[k] = $signed(5'(kr) - 5'(k) - 5'(up_r) - 5'd1);
            if (roff[k] < -$signed({3'b0, lo_y})) begin
                roff[k] = -$signed({3'b0, lo_y});
            end else if (roff[k] > $signed({3'b0, hi_y})) begin
                roff[k] = $signed({3'b0, hi_y});
            end
            rv[k] = $signed({2'b0, s1_reg.s}) + roff[k];
            if (rv[k] < 5'sd0) begin
                rv[k] = rv[k] + 5'sd6;
            end else if (rv[k] >= 5'sd6) begin
                rv[k] = rv[k] - 5'sd6;
            end
            s2_next.slot[k] = SLOT_W'(rv[k]);

            coff[k] = $signed(5'(kc) - 5'(k) - 5'(up_c) - 5'd1);
            if (coff[k] < -$signed({3'b0, lo_x})) begin
                coff[k] = -$signed({3'b0, lo_x});
            end else if (coff[k] > $signed({3'b0, hi_x})) begin
                coff[k] = $signed({3'b0, hi_x});
            end
            cv[k] = $signed({2'b0, s1_reg.r}) + coff[k];
            if (cv[k] < 5'sd0) begin
                cv[k] = cv[k] + 5'sd5;
            end else if (cv[k] >= 5'sd5) begin
                cv[k] = cv[k] - 5'sd5;
            end
            s2_next.phase[k] = PHASE_W'(cv[k]);
        end
    end

    crb_line_store u_line_store (
        .aclk     (aclk),
        .wr_en    (is_pix),
        .wr_slot  (in_s_reg),
        .wr_phase (in_r_reg),
        .wr_addr  (in_q_reg),
        .wr_data  (pixel),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // window gather into the first cell
    always_comb begin
        gather_tok       = '0;
        gather_tok.kind  = s2_reg.kind;
        gather_tok.x     = s2_reg.x;
        gather_tok.y     = s2_reg.y;
        gather_tok.eof   = s2_reg.eof;
        gather_tok.tap   = s2_reg.tap;
        gather_tok.value = s2_reg.value;
        for (int r = 0; r < MAX_KERNEL; r++) begin
            for (int c = 0; c < MAX_KERNEL; c++) begin
                if (3'(r) < kr && 3'(c) < kc) begin
                    gather_tok.pix[r * MAX_KERNEL + c] =
                        rd_data[s2_reg.slot[r]][s2_reg.phase[c]];
                end
            end
        end
    end

    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_cell
        if (t == 0) begin : g_first
            crb_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (gather_tok),
                .tok_out (cell_q[t])
            );
        end else begin : g_next
            crb_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (cell_q[t-1]),
                .tok_out (cell_q[t])
            );
        end
    end

    // rounding half up from Q4.12 and saturation
    assign last_tok = cell_q[NUM_TAPS-1];
    assign rnd      = (SUM_W + 1)'(last_tok.sum) + (SUM_W + 1)'(2048);
    assign qv       = rnd[SUM_W:12];

    always_comb begin
        fifo_wr.eof = last_tok.eof;
        fifo_wr.x   = last_tok.x;
        fifo_wr.y   = last_tok.y;
        if (qv > Q_W'(32767)) begin
            fifo_wr.filtered = 16'sh7FFF;
        end else if (qv < -Q_W'(32768)) begin
            fifo_wr.filtered = 16'sh8000;
        end else begin
            fifo_wr.filtered = qv[15:0];
        end
    end

    crb_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (last_tok.kind == TK_RESULT),
        .wr_data  (fifo_wr),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (fifo_rd)
    );

    assign m_tdata = {2'b00, fifo_rd.y, fifo_rd.x, fifo_rd.filtered};
    assign m_tlast = fifo_rd.eof;

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("outstanding result count overran the output queue");

    a_result_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        last_tok.kind == TK_RESULT |-> pend_reg != '0)
        else $error("result left the cell chain without being counted");

    a_tail_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg |-> (in_x_reg == '0 && in_y_reg == '0))
        else $error("frame tail pending with input position off origin");

    a_emit_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (ex_reg <= wm1 && ey_reg <= hm1))
        else $error("emit position outside the frame");

endmodule

`default_nettype wire
